// ===== sv/nzda_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and lookup functions for the ZDA time parser.
// No dependencies; imported by the controller, datapath and top level.
package nzda_pkg;

    // Fixed sentence layout
    localparam int POS_W   = 5;
    typedef logic [POS_W-1:0] pos_t;

    localparam pos_t ZDA_FIRST_POS = 5'd7;
    localparam pos_t ZDA_LAST_POS  = 5'd26;
    localparam int   ZDA_LEN       = 36;
    localparam int   HDR_LEN       = 6;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Field and result widths
    localparam int OFFSET_W = 17;
    localparam int EPOCH_W  = 39;
    localparam int YEAR_W   = 14;
    localparam int FIELD_W  = 7;
    localparam int MS_W     = 32;
    localparam int DAYS_W   = 24;
    localparam int TOD_W    = 20;

    // Calendar arithmetic constants
    localparam int MON_RECIP       = 171;    // 2^11 / 12, rounded up
    localparam int ERA_RECIP       = 10486;  // 2^22 / 400, rounded up
    localparam int YEARS_PER_ERA   = 400;
    localparam int DAYS_PER_YEAR   = 365;
    localparam int DAYS_PER_ERA    = 146097;
    localparam int EPOCH_DAY_SHIFT = 719469; // civil offset plus one for day-of-month base
    localparam int SEC_PER_DAY     = 86400;
    localparam int SEC_PER_HOUR    = 3600;
    localparam int SEC_PER_MIN     = 60;

    typedef enum logic [2:0] {
        FLD_NONE,
        FLD_HOUR,
        FLD_MINUTE,
        FLD_SECOND,
        FLD_DAY,
        FLD_MONTH,
        FLD_YEAR
    } field_t;

    typedef enum logic [3:0] {
        STEP_NONE,
        STEP_MON_DIV,
        STEP_YEAR,
        STEP_ERA,
        STEP_YOE,
        STEP_DOE,
        STEP_DAYS,
        STEP_SCALE,
        STEP_SUM
    } calc_step_t;

    typedef struct packed {
        logic       take;      // input transaction this cycle
        logic       start;     // line end of a matching sentence
        logic       rd_en;
        pos_t       rd_pos;
        logic       dig_valid; // read data for dig_pos is present
        pos_t       dig_pos;
        calc_step_t step;
        logic       load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic is_eol;
        logic match;
        logic len36;
    } dp_status_t;

    function automatic field_t field_of(input pos_t pos);
        field_t f;
        case (pos)
            5'd7, 5'd8:                 f = FLD_HOUR;
            5'd9, 5'd10:                f = FLD_MINUTE;
            5'd11, 5'd12:               f = FLD_SECOND;
            5'd17, 5'd18:               f = FLD_DAY;
            5'd20, 5'd21:               f = FLD_MONTH;
            5'd23, 5'd24, 5'd25, 5'd26: f = FLD_YEAR;
            default:                    f = FLD_NONE;
        endcase
        return f;
    endfunction

    function automatic logic field_first(input pos_t pos);
        logic first;
        case (pos)
            5'd7, 5'd9, 5'd11, 5'd17, 5'd20, 5'd23: first = 1'b1;
            default:                                first = 1'b0;
        endcase
        return first;
    endfunction

    function automatic logic [7:0] hdr_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = CH_DOLLAR;
            3'd1:    c = 8'h47; // G
            3'd2:    c = 8'h50; // P
            3'd3:    c = 8'h5A; // Z
            3'd4:    c = 8'h44; // D
            3'd5:    c = 8'h41; // A
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Day of a March-based year on which month index starts
    function automatic logic [8:0] doy_start(input logic [3:0] midx);
        logic [8:0] d;
        case (midx)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// ===== sv/nzda_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer of the ZDA time parser: input handshake, digit read sweep,
// calendar step sequence and output handshake. Uses nzda_pkg.
module nzda_ctrl
    import nzda_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_MON_DIV,
        ST_YEAR,
        ST_ERA,
        ST_YOE,
        ST_DOE,
        ST_DAYS,
        ST_SCALE,
        ST_SUM,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    pos_t   rd_pos_reg, rd_pos_next;
    logic   tag_valid_reg, tag_valid_next;
    pos_t   tag_pos_reg, tag_pos_next;
    logic   m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        cmd            = '0;
        cmd.step       = STEP_NONE;
        state_next     = state_reg;
        rd_pos_next    = rd_pos_reg;
        tag_valid_next = 1'b0;
        tag_pos_next   = rd_pos_reg;

        cmd.take      = (state_reg == ST_IDLE) && s_valid;
        cmd.start     = cmd.take && status.is_eol && status.match;
        cmd.rd_pos    = rd_pos_reg;
        cmd.dig_valid = tag_valid_reg;
        cmd.dig_pos   = tag_pos_reg;

        case (state_reg)
            ST_IDLE: begin
                if (cmd.start) begin
                    rd_pos_next = ZDA_FIRST_POS;
                    state_next  = status.len36 ? ST_READ : ST_DONE;
                end
            end
            ST_READ: begin
                cmd.rd_en      = 1'b1;
                tag_valid_next = 1'b1;
                rd_pos_next    = rd_pos_reg + 1'b1;
                if (rd_pos_reg == ZDA_LAST_POS) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:   state_next = ST_MON_DIV;
            ST_MON_DIV: begin
                cmd.step   = STEP_MON_DIV;
                state_next = ST_YEAR;
            end
            ST_YEAR: begin
                cmd.step   = STEP_YEAR;
                state_next = ST_ERA;
            end
            ST_ERA: begin
                cmd.step   = STEP_ERA;
                state_next = ST_YOE;
            end
            ST_YOE: begin
                cmd.step   = STEP_YOE;
                state_next = ST_DOE;
            end
            ST_DOE: begin
                cmd.step   = STEP_DOE;
                state_next = ST_DAYS;
            end
            ST_DAYS: begin
                cmd.step   = STEP_DAYS;
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.step   = STEP_SCALE;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.step   = STEP_SUM;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else begin
            m_valid_next = m_valid_reg && !m_ready;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            rd_pos_reg    <= ZDA_FIRST_POS;
            tag_valid_reg <= 1'b0;
            tag_pos_reg   <= ZDA_FIRST_POS;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rd_pos_reg    <= rd_pos_next;
            tag_valid_reg <= tag_valid_next;
            tag_pos_reg   <= tag_pos_next;
            m_valid_reg   <= m_valid_next;
        end
    end

endmodule

// ===== sv/nzda_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the ZDA time parser: sentence store, header and length
// tracking, digit decode, calendar arithmetic and output register. Uses nzda_pkg.
module nzda_datapath
    import nzda_pkg::*;
#(
    parameter int STORE_BYTES = 64
)
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  dp_cmd_t                    cmd,
    output dp_status_t                 status,
    input  logic [7:0]                 s_char_in,
    input  logic [MS_W-1:0]            s_now_ms,
    input  logic                       cfg_wr_en,
    input  logic signed [OFFSET_W-1:0] cfg_wr_data,
    output logic                       m_time_ok,
    output logic [YEAR_W-1:0]          m_year_val,
    output logic [FIELD_W-1:0]         m_month_val,
    output logic [FIELD_W-1:0]         m_day_val,
    output logic [FIELD_W-1:0]         m_hour_val,
    output logic [FIELD_W-1:0]         m_minute_val,
    output logic [FIELD_W-1:0]         m_second_val,
    output logic signed [EPOCH_W-1:0]  m_utc_epoch,
    output logic [MS_W-1:0]            m_rx_ms
);

    localparam int AW = $clog2(STORE_BYTES);
    typedef logic [AW-1:0] addr_t;

    // Sentence store and its bookkeeping
    logic [7:0] store_mem [STORE_BYTES];
    logic [7:0] rd_data_reg;
    addr_t      write_pos_reg;
    addr_t      len_reg;
    logic       zero_seen_reg;
    logic       hdr_ok_reg;
    logic signed [OFFSET_W-1:0] offset_reg;

    logic  is_dollar, is_eol, store_ok, mem_we;
    addr_t mem_waddr;
    logic [7:0] mem_wdata;

    // Digit decode
    logic [YEAR_W-1:0] acc_reg, acc_next, acc_base, acc_x10;
    logic              run_reg, run_next, run_base;
    field_t            dig_field;
    logic              dig_is_num;
    logic [3:0]        dig_val;
    logic [7:0]        dig_off;

    // Working result
    logic                      time_ok_reg;
    logic [YEAR_W-1:0]         year_reg;
    logic [FIELD_W-1:0]        month_reg, day_reg, hour_reg, minute_reg, second_reg;
    logic signed [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic [MS_W-1:0]           rx_ms_reg;

    // Calendar pipeline registers
    logic [3:0]               mq_reg, mq_next;
    logic signed [14:0]       y_reg, y_next;
    logic [3:0]               midx_reg, midx_next;
    logic signed [5:0]        era_reg, era_next;
    logic [8:0]               yoe_reg, yoe_next;
    logic [17:0]              doe_reg, doe_next;
    logic signed [DAYS_W-1:0] days_reg, days_next;
    logic signed [EPOCH_W-1:0] scale_reg, scale_next;
    logic signed [TOD_W-1:0]  tod_reg, tod_next;

    logic [6:0]         mon_m1, mon_r_raw;
    logic [14:0]        mon_prod;
    logic               mon_zero;
    logic [3:0]         mon_r;
    logic signed [14:0] y_base;
    logic [27:0]        era_prod;
    logic signed [15:0] era_x400, yoe_full;
    logic [1:0]         cent;
    logic signed [DAYS_W-1:0] era_days;
    logic signed [41:0] scale_prod;
    logic [18:0]        tod_sum;

    // Result register
    logic                      out_time_ok_reg;
    logic [YEAR_W-1:0]         out_year_reg;
    logic [FIELD_W-1:0]        out_month_reg, out_day_reg, out_hour_reg;
    logic [FIELD_W-1:0]        out_minute_reg, out_second_reg;
    logic signed [EPOCH_W-1:0] out_epoch_reg;
    logic [MS_W-1:0]           out_rx_ms_reg;

    // Input classification and store write
    assign is_dollar = (s_char_in == CH_DOLLAR);
    assign is_eol    = (s_char_in == CH_CR) || (s_char_in == CH_LF);
    assign store_ok  = !is_eol && !is_dollar && (write_pos_reg != addr_t'(STORE_BYTES - 1));
    assign mem_we    = cmd.take && (is_dollar || store_ok);
    assign mem_waddr = is_dollar ? '0 : write_pos_reg;
    assign mem_wdata = s_char_in;

    assign status.is_eol = is_eol;
    assign status.match  = hdr_ok_reg && (write_pos_reg >= addr_t'(HDR_LEN));
    assign status.len36  = (len_reg == addr_t'(ZDA_LEN));

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= store_mem[addr_t'(cmd.rd_pos)];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            write_pos_reg <= '0;
            len_reg       <= '0;
            zero_seen_reg <= 1'b1;
            hdr_ok_reg    <= 1'b0;
            offset_reg    <= '0;
        end else begin
            if (cfg_wr_en) begin
                offset_reg <= cfg_wr_data;
            end
            if (cmd.take && is_dollar) begin
                write_pos_reg <= addr_t'(1);
                len_reg       <= addr_t'(1);
                zero_seen_reg <= 1'b0;
                hdr_ok_reg    <= 1'b1;
            end else if (cmd.take && store_ok) begin
                write_pos_reg <= write_pos_reg + 1'b1;
                if (!zero_seen_reg) begin
                    if (s_char_in == 8'h00) begin
                        zero_seen_reg <= 1'b1;
                    end else begin
                        len_reg <= len_reg + 1'b1;
                    end
                end
                if (write_pos_reg < addr_t'(HDR_LEN)) begin
                    hdr_ok_reg <= hdr_ok_reg && (s_char_in == hdr_char(write_pos_reg[2:0]));
                end
            end
        end
    end

    // Leading-digit run per field; a non-digit ends the run
    always_comb begin
        dig_field  = field_of(cmd.dig_pos);
        acc_base   = field_first(cmd.dig_pos) ? '0 : acc_reg;
        run_base   = field_first(cmd.dig_pos) || run_reg;
        dig_is_num = (rd_data_reg >= CH_ZERO) && (rd_data_reg <= CH_NINE);
        dig_off    = rd_data_reg - CH_ZERO;
        dig_val    = dig_off[3:0];
        acc_x10    = {acc_base[10:0], 3'b000} + {acc_base[12:0], 1'b0};
        if (run_base && dig_is_num) begin
            acc_next = acc_x10 + YEAR_W'(dig_val);
            run_next = 1'b1;
        end else begin
            acc_next = acc_base;
            run_next = 1'b0;
        end
    end

    // Calendar arithmetic, one registered step per command
    always_comb begin
        mon_zero  = (month_reg == '0);
        mon_m1    = month_reg - 7'd1;
        mon_prod  = 15'(mon_m1) * 15'(MON_RECIP);
        mq_next   = mon_prod[14:11];
        mon_r_raw = mon_m1 - ({mq_reg, 3'b000} + 7'({mq_reg, 2'b00}));
        mon_r     = mon_zero ? 4'd11 : mon_r_raw[3:0];
        if (mon_zero) begin
            y_base = $signed({1'b0, year_reg}) - 15'sd1;
        end else begin
            y_base = $signed({1'b0, year_reg}) + $signed(15'(mq_reg));
        end
        // January and February belong to the previous March-based year
        y_next    = (mon_r < 4'd2) ? (y_base - 15'sd1) : y_base;
        midx_next = (mon_r >= 4'd2) ? (mon_r - 4'd2) : (mon_r + 4'd10);

        era_prod = 28'(y_reg[13:0]) * 28'(ERA_RECIP);
        era_next = y_reg[14] ? -6'sd1 : $signed({1'b0, era_prod[26:22]});

        era_x400 = 16'(era_reg) * 16'sd400;
        yoe_full = 16'(y_reg) - era_x400;
        yoe_next = yoe_full[8:0];

        if (yoe_reg >= 9'd300) begin
            cent = 2'd3;
        end else if (yoe_reg >= 9'd200) begin
            cent = 2'd2;
        end else if (yoe_reg >= 9'd100) begin
            cent = 2'd1;
        end else begin
            cent = 2'd0;
        end
        doe_next = 18'(yoe_reg) * 18'(DAYS_PER_YEAR) + 18'(yoe_reg[8:2])
                 - 18'(cent) + 18'(doy_start(midx_reg));

        era_days  = 24'(era_reg) * 24'sd146097;
        days_next = era_days + $signed(24'(doe_reg)) + $signed(24'(day_reg))
                  - 24'sd719469;

        scale_prod = days_reg * 18'sd86400;
        scale_next = $signed(scale_prod[EPOCH_W-1:0]);
        tod_sum    = 19'(hour_reg) * 19'(SEC_PER_HOUR) + 19'(minute_reg) * 19'(SEC_PER_MIN)
                   + 19'(second_reg);
        tod_next   = $signed({1'b0, tod_sum}) + TOD_W'(offset_reg);

        epoch_next = scale_reg + EPOCH_W'(tod_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            time_ok_reg <= status.len36;
            rx_ms_reg   <= s_now_ms;
            year_reg    <= '0;
            month_reg   <= '0;
            day_reg     <= '0;
            hour_reg    <= '0;
            minute_reg  <= '0;
            second_reg  <= '0;
            epoch_reg   <= '0;
        end else begin
            if (cmd.dig_valid) begin
                acc_reg <= acc_next;
                run_reg <= run_next;
                case (dig_field)
                    FLD_HOUR:   hour_reg   <= acc_next[FIELD_W-1:0];
                    FLD_MINUTE: minute_reg <= acc_next[FIELD_W-1:0];
                    FLD_SECOND: second_reg <= acc_next[FIELD_W-1:0];
                    FLD_DAY:    day_reg    <= acc_next[FIELD_W-1:0];
                    FLD_MONTH:  month_reg  <= acc_next[FIELD_W-1:0];
                    FLD_YEAR:   year_reg   <= acc_next;
                    default:    ;
                endcase
            end
            case (cmd.step)
                STEP_MON_DIV: mq_reg <= mq_next;
                STEP_YEAR: begin
                    y_reg    <= y_next;
                    midx_reg <= midx_next;
                end
                STEP_ERA:   era_reg  <= era_next;
                STEP_YOE:   yoe_reg  <= yoe_next;
                STEP_DOE:   doe_reg  <= doe_next;
                STEP_DAYS:  days_reg <= days_next;
                STEP_SCALE: begin
                    scale_reg <= scale_next;
                    tod_reg   <= tod_next;
                end
                STEP_SUM:   epoch_reg <= epoch_next;
                default:    ;
            endcase
        end
        if (cmd.load_out) begin
            out_time_ok_reg <= time_ok_reg;
            out_year_reg    <= year_reg;
            out_month_reg   <= month_reg;
            out_day_reg     <= day_reg;
            out_hour_reg    <= hour_reg;
            out_minute_reg  <= minute_reg;
            out_second_reg  <= second_reg;
            out_epoch_reg   <= epoch_reg;
            out_rx_ms_reg   <= rx_ms_reg;
        end
    end

    assign m_time_ok    = out_time_ok_reg;
    assign m_year_val   = out_year_reg;
    assign m_month_val  = out_month_reg;
    assign m_day_val    = out_day_reg;
    assign m_hour_val   = out_hour_reg;
    assign m_minute_val = out_minute_reg;
    assign m_second_val = out_second_reg;
    assign m_utc_epoch  = out_epoch_reg;
    assign m_rx_ms      = out_rx_ms_reg;

endmodule

// ===== sv/nmea_zda_time_parser_unit.sv =====
`timescale 1ns / 1ps
// Top level of the NMEA ZDA time parser: controller plus datapath.
// Depends on nzda_pkg, nzda_ctrl and nzda_datapath.
//
// The unit takes one received character per transaction, with its millisecond
// arrival time, and builds the current sentence in a STORE_BYTES-deep store.
// A '$' starts a new sentence; CR and LF are never stored. Each CR or LF that
// ends a sentence beginning with "$GPZDA" produces one result transaction, so a
// CR LF pair gives two. When the text up to the first zero byte is exactly 36
// characters long, the result carries the decoded date and time digits and the
// epoch seconds of that UTC time (months out of range roll into the year, other
// fields overflow arithmetically) plus the signed offset written through
// cfg_wr_en/cfg_wr_data; otherwise time_ok is low and only rx_ms is meaningful.
// An ordinary character, or a line end with no result, leaves the unit idle. A
// line end of a 36-character sentence sweeps the digit positions through the
// store's single read port, then runs eight registered calendar steps, taking no
// characters meanwhile; a short sentence goes straight to the output stage. The
// result waits in an output register; characters flow on up to the next result.
// The store needs no clearing pass after reset: header and length tracking
// guarantee that only entries written since the last '$' are ever read.
module nmea_zda_time_parser_unit
    import nzda_pkg::*;
#(
    parameter int STORE_BYTES = 64
)
(
    input  logic                       aclk,
    input  logic                       aresetn,
    // Configuration
    input  logic                       cfg_wr_en,
    input  logic signed [OFFSET_W-1:0] cfg_wr_data,
    // Character input
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [7:0]                 s_char_in,
    input  logic [MS_W-1:0]            s_now_ms,
    // Result output
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_time_ok,
    output logic [YEAR_W-1:0]          m_year_val,
    output logic [FIELD_W-1:0]         m_month_val,
    output logic [FIELD_W-1:0]         m_day_val,
    output logic [FIELD_W-1:0]         m_hour_val,
    output logic [FIELD_W-1:0]         m_minute_val,
    output logic [FIELD_W-1:0]         m_second_val,
    output logic signed [EPOCH_W-1:0]  m_utc_epoch,
    output logic [MS_W-1:0]            m_rx_ms
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    // Sequencing: handshakes, digit read sweep, calendar steps
    nzda_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (dp_status),
        .cmd     (dp_cmd)
    );

    // Store, decode, arithmetic and result register
    nzda_datapath #(
        .STORE_BYTES (STORE_BYTES)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (dp_cmd),
        .status       (dp_status),
        .s_char_in    (s_char_in),
        .s_now_ms     (s_now_ms),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .m_time_ok    (m_time_ok),
        .m_year_val   (m_year_val),
        .m_month_val  (m_month_val),
        .m_day_val    (m_day_val),
        .m_hour_val   (m_hour_val),
        .m_minute_val (m_minute_val),
        .m_second_val (m_second_val),
        .m_utc_epoch  (m_utc_epoch),
        .m_rx_ms      (m_rx_ms)
    );

endmodule

// ===== sv/nzda_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the ZDA time parser, bound to the top level.
// Depends on nzda_pkg and nmea_zda_time_parser_unit.
module nzda_checker
    import nzda_pkg::*;
(
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       cfg_wr_en,
    input logic signed [OFFSET_W-1:0] cfg_wr_data,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic [7:0]                 s_char_in,
    input logic [MS_W-1:0]            s_now_ms,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic                       m_time_ok,
    input logic [YEAR_W-1:0]          m_year_val,
    input logic [FIELD_W-1:0]         m_month_val,
    input logic [FIELD_W-1:0]         m_day_val,
    input logic [FIELD_W-1:0]         m_hour_val,
    input logic [FIELD_W-1:0]         m_minute_val,
    input logic [FIELD_W-1:0]         m_second_val,
    input logic signed [EPOCH_W-1:0]  m_utc_epoch,
    input logic [MS_W-1:0]            m_rx_ms
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_utc_epoch)
            && $stable(m_rx_ms) && $stable(m_time_ok))
        else $error("result changed while stalled");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A sentence of the wrong length reports zeros
    a_short_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_time_ok |-> m_year_val == '0 && m_month_val == '0
            && m_day_val == '0 && m_hour_val == '0 && m_minute_val == '0
            && m_second_val == '0 && m_utc_epoch == '0)
        else $error("fields not zero without decoded time");

    // Decoded fields are digit runs of at most two or four digits
    a_digit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_time_ok |-> m_year_val <= 14'd9999 && m_month_val <= 7'd99
            && m_day_val <= 7'd99 && m_hour_val <= 7'd99
            && m_minute_val <= 7'd99 && m_second_val <= 7'd99)
        else $error("decoded field out of digit range");

endmodule

bind nmea_zda_time_parser_unit nzda_checker u_nzda_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for nmea_zda_time_parser_unit.
// Depends on nzda_pkg and the unit; drives characters and checks ZDA time fixes.
module tb_top;
    import nzda_pkg::*;

    localparam int LINE_BYTES     = 64;
    localparam int SETTLE_CYCLES  = 48;        // covers the decode of a line end
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam logic [47:0] ZDA_TAG = "$GPZDA";

    typedef logic [7:0] text_t[$];

    // One expected time fix, field by field at the port widths
    typedef struct packed {
        logic                       time_ok;
        logic [YEAR_W-1:0]          year;
        logic [FIELD_W-1:0]         month;
        logic [FIELD_W-1:0]         day;
        logic [FIELD_W-1:0]         hour;
        logic [FIELD_W-1:0]         minute;
        logic [FIELD_W-1:0]         second;
        logic signed [EPOCH_W-1:0]  epoch;
        logic [MS_W-1:0]            rx_ms;
    } zda_fix_t;

    logic                       aclk = 1'b0;
    logic                       aresetn;
    logic                       cfg_wr_en;
    logic signed [OFFSET_W-1:0] cfg_wr_data;
    logic                       s_valid;
    logic                       s_ready;
    logic [7:0]                 s_char_in;
    logic [MS_W-1:0]            s_now_ms;
    logic                       m_valid;
    logic                       m_ready;
    logic                       m_time_ok;
    logic [YEAR_W-1:0]          m_year_val;
    logic [FIELD_W-1:0]         m_month_val;
    logic [FIELD_W-1:0]         m_day_val;
    logic [FIELD_W-1:0]         m_hour_val;
    logic [FIELD_W-1:0]         m_minute_val;
    logic [FIELD_W-1:0]         m_second_val;
    logic signed [EPOCH_W-1:0]  m_utc_epoch;
    logic [MS_W-1:0]            m_rx_ms;

    // Shadow of the sentence store, its write pointer and the offset register
    logic [7:0]   line_buf [LINE_BYTES];
    int unsigned  line_wr_pos = 0;
    longint       utc_offset  = 0;

    zda_fix_t     fixes_due[$];
    int unsigned  fix_mismatches = 0;
    int unsigned  chars_sent     = 0;
    int unsigned  cycle_count    = 0;
    bit           gaps_on        = 1'b1;
    bit           stalls_on      = 1'b1;
    int unsigned  hold_off_len   = 0;

    nmea_zda_time_parser_unit #(
        .STORE_BYTES(LINE_BYTES)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_char_in    (s_char_in),
        .s_now_ms     (s_now_ms),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_time_ok    (m_time_ok),
        .m_year_val   (m_year_val),
        .m_month_val  (m_month_val),
        .m_day_val    (m_day_val),
        .m_hour_val   (m_hour_val),
        .m_minute_val (m_minute_val),
        .m_second_val (m_second_val),
        .m_utc_epoch  (m_utc_epoch),
        .m_rx_ms      (m_rx_ms)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Hard stop: a hang or a lost result ends here
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Calendar arithmetic, with floor semantics for the division of negative values
    // ------------------------------------------------------------------
    function automatic longint div_floor(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b != 0) && (a < 0))
            q = q - 1;
        return q;
    endfunction

    // Days from 1970-01-01 to the first of month m (1..12) of year y
    function automatic longint days_to_month(longint y, longint m);
        longint era, yoe, doy, doe;
        if (m <= 2)
            y = y - 1;
        era = div_floor(y, YEARS_PER_ERA);
        yoe = y - era * YEARS_PER_ERA;
        doy = (153 * (m + ((m > 2) ? -3 : 9)) + 2) / 5;
        doe = yoe * DAYS_PER_YEAR + yoe / 4 - yoe / 100 + doy;
        return era * DAYS_PER_ERA + doe - 719468;
    endfunction

    // Value of the run of leading decimal digits in a fixed field
    function automatic longint lead_digits(int first, int count);
        longint v;
        bit     stop;
        int     i;
        v    = 0;
        stop = 1'b0;
        for (i = 0; i < count; i++) begin
            if (line_buf[first+i] < CH_ZERO || line_buf[first+i] > CH_NINE)
                stop = 1'b1;
            if (!stop)
                v = v * 10 + (line_buf[first+i] - CH_ZERO);
        end
        return v;
    endfunction

    // Advance the shadow store by one accepted character; queue the fix
    // that a line end of a "$GPZDA" sentence produces.
    function automatic void track_sentence_char(logic [7:0] c, logic [MS_W-1:0] ms);
        zda_fix_t    fix;
        bit          tag_ok;
        int unsigned text_len;
        int          i;
        longint      yr, mo, dy, hr, mi, se, m0, y, mm, days, secs;
        if (c == CH_CR || c == CH_LF) begin
            line_buf[LINE_BYTES-1] = 8'h00;
            tag_ok = 1'b1;
            for (i = 0; i < HDR_LEN; i++)
                if (line_buf[i] != ZDA_TAG[47-8*i -: 8])
                    tag_ok = 1'b0;
            if (tag_ok) begin
                fix       = '0;
                fix.rx_ms = ms;
                text_len  = 0;
                while (text_len < LINE_BYTES - 1 && line_buf[text_len] != 8'h00)
                    text_len++;
                if (text_len == ZDA_LEN) begin
                    yr   = lead_digits(23, 4);
                    mo   = lead_digits(20, 2);
                    dy   = lead_digits(17, 2);
                    hr   = lead_digits(7, 2);
                    mi   = lead_digits(9, 2);
                    se   = lead_digits(11, 2);
                    // roll months outside 1..12 into the year
                    m0   = mo - 1;
                    y    = yr + div_floor(m0, 12);
                    mm   = m0 - div_floor(m0, 12) * 12;
                    days = days_to_month(y, mm + 1) + dy - 1;
                    secs = days * SEC_PER_DAY + hr * SEC_PER_HOUR + mi * SEC_PER_MIN
                         + se + utc_offset;
                    fix.time_ok = 1'b1;
                    fix.year    = yr[YEAR_W-1:0];
                    fix.month   = mo[FIELD_W-1:0];
                    fix.day     = dy[FIELD_W-1:0];
                    fix.hour    = hr[FIELD_W-1:0];
                    fix.minute  = mi[FIELD_W-1:0];
                    fix.second  = se[FIELD_W-1:0];
                    fix.epoch   = secs[EPOCH_W-1:0];
                end
                fixes_due.push_back(fix);
            end
        end else if (c == CH_DOLLAR) begin
            foreach (line_buf[k])
                line_buf[k] = 8'h00;
            line_buf[0] = c;
            line_wr_pos = 1;
        end else if (line_wr_pos < LINE_BYTES - 1) begin
            line_buf[line_wr_pos] = c;
            line_wr_pos++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checking: compare every accepted fix with the oldest one due
    // ------------------------------------------------------------------
    function automatic void check_field(string name, logic signed [63:0] want,
                                        logic signed [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fix_mismatches++;
        end
    endfunction

    always @(posedge aclk) begin : fix_check
        zda_fix_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (fixes_due.size() == 0) begin
                $error("unexpected result transaction, rx_ms %0d", m_rx_ms);
                fix_mismatches++;
            end else begin
                want = fixes_due.pop_front();
                check_field("time_ok",    want.time_ok, m_time_ok);
                check_field("year_val",   want.year,    m_year_val);
                check_field("month_val",  want.month,   m_month_val);
                check_field("day_val",    want.day,     m_day_val);
                check_field("hour_val",   want.hour,    m_hour_val);
                check_field("minute_val", want.minute,  m_minute_val);
                check_field("second_val", want.second,  m_second_val);
                check_field("utc_epoch",  want.epoch,   m_utc_epoch);
                check_field("rx_ms",      want.rx_ms,   m_rx_ms);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random stall bursts, plus a long hold-off on request
    // ------------------------------------------------------------------
    initial begin : fix_receiver
        int unsigned burst;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_off_len != 0) begin
                // hold the output for the whole stretch so the unit backs up
                m_ready = 1'b0;
                repeat (hold_off_len) @(negedge aclk);
                hold_off_len = 0;
            end else if (stalls_on && $urandom_range(0, 5) == 0) begin
                m_ready = 1'b0;
                burst = $urandom_range(1, 14);
                repeat (burst - 1) @(negedge aclk);
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers; every task starts and ends at a falling edge
    // ------------------------------------------------------------------

    // Offer one character until the unit takes it; valid stays up meanwhile
    task automatic send_char(logic [7:0] c, logic [MS_W-1:0] ms);
        int unsigned gap;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 14);
            repeat (gap) @(negedge aclk);
        end
        s_valid   = 1'b1;
        s_char_in = c;
        s_now_ms  = ms;
        @(posedge aclk);
        while (s_ready !== 1'b1)
            @(posedge aclk);
        track_sentence_char(c, ms);
        chars_sent++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic send_text(text_t txt);
        int i;
        for (i = 0; i < txt.size(); i++)
            send_char(txt[i], $urandom());
    endtask

    // Build a well-formed 36-character ZDA sentence with its checksum
    function automatic text_t zda_text(int hh, int mi, int ss, int dd, int mo, int yy);
        string      body;
        logic [7:0] sum;
        text_t      txt;
        int         i;
        body = $sformatf("GPZDA,%02d%02d%02d.00,%02d,%02d,%04d,00,00",
                         hh, mi, ss, dd, mo, yy);
        sum = 8'h00;
        for (i = 0; i < body.len(); i++)
            sum ^= body[i];
        body = {"$", body, $sformatf("*%02X", sum)};
        for (i = 0; i < body.len(); i++)
            txt.push_back(body[i]);
        return txt;
    endfunction

    // Wait until every fix has arrived, then let a pending decode finish
    task automatic wait_idle();
        while (fixes_due.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_utc_offset(int secs);
        wait_idle();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = secs[OFFSET_W-1:0];
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
        utc_offset  = secs;
    endtask

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Line ends on an empty store and on text that precedes any '$'
    task automatic test_text_before_dollar();
        text_t txt;
        send_char(CH_CR, $urandom());
        txt = zda_text(1, 2, 3, 4, 5, 2006);
        void'(txt.pop_front());
        send_text(txt);
        send_char(CH_LF, $urandom());
    endtask

    // Normal sentence ended by CR LF: two fixes, timestamps at the extremes
    task automatic test_plain_fix();
        send_text(zda_text(12, 34, 56, 15, 6, 2024));
        send_char(CH_CR, 32'h0000_0000);
        send_char(CH_LF, 32'hFFFF_FFFF);
    endtask

    // Lowest and highest digits, under the extreme offsets
    task automatic test_field_extremes();
        set_utc_offset(-50400);
        send_text(zda_text(0, 0, 0, 0, 0, 0));
        send_char(CH_LF, $urandom());
        set_utc_offset(50400);
        send_text(zda_text(99, 99, 99, 99, 99, 9999));
        send_char(CH_CR, $urandom());
        set_utc_offset(0);
    endtask

    // Spaces, signs and letters stop a digit run
    task automatic test_broken_digits();
        text_t txt;
        txt     = zda_text(23, 59, 58, 31, 12, 1999);
        txt[7]  = " ";
        txt[10] = "-";
        txt[12] = "+";
        txt[17] = "+";
        txt[21] = "x";
        txt[25] = "A";
        send_text(txt);
        send_char(CH_CR, $urandom());
        txt     = zda_text(10, 20, 30, 28, 2, 2000);
        txt[8]  = ":";
        txt[20] = " ";
        txt[23] = "-";
        send_text(txt);
        send_char(CH_LF, $urandom());
    endtask

    // Wrong lengths, another sentence type, zero bytes and a full store
    task automatic test_odd_lengths();
        text_t txt;
        int    i;
        txt = zda_text(1, 1, 1, 1, 1, 2001);
        txt.delete(30);                       // one short
        send_text(txt);
        send_char(CH_CR, $urandom());
        txt = zda_text(2, 2, 2, 2, 2, 2002);
        txt.insert(30, "0");                  // one long
        send_text(txt);
        send_char(CH_LF, $urandom());
        txt = zda_text(3, 3, 3, 3, 3, 2003);
        txt[3] = "G";
        txt[4] = "G";                         // $GPGGA gives nothing
        send_text(txt);
        send_char(CH_CR, $urandom());
        txt = zda_text(4, 4, 4, 4, 4, 2004);  // zero byte after the text: still 36
        txt.push_back(8'h00);
        txt.push_back("7");
        send_text(txt);
        send_char(CH_CR, $urandom());
        txt = zda_text(5, 5, 5, 5, 5, 2005);  // zero byte inside: length 20
        txt[20] = 8'h00;
        send_text(txt);
        send_char(CH_LF, $urandom());
        send_text(zda_text(6, 6, 6, 6, 6, 2006));
        send_char(CH_CR, $urandom());         // the store survives the line end
        send_char("X", $urandom());
        send_char(CH_LF, $urandom());
        txt = zda_text(7, 7, 7, 7, 7, 2007);
        for (i = 0; i < 40; i++)
            txt.push_back("9");               // past the end of the store
        send_text(txt);
        send_char(CH_CR, $urandom());
    endtask

    // Hold the output for a long stretch while sentences keep coming in
    task automatic test_stalled_output();
        int n;
        wait_idle();
        hold_off_len = 400;
        for (n = 0; n < 3; n++) begin
            send_text(zda_text(n, 10 + n, 20 + n, 1 + n, 1 + n, 2010 + n));
            send_char(CH_CR, $urandom());
            send_char(CH_LF, $urandom());
        end
    endtask

    // ------------------------------------------------------------------
    // Random traffic
    // ------------------------------------------------------------------
    task automatic send_noise();
        int         n;
        logic [7:0] c;
        n = $urandom_range(1, 8);
        repeat (n) begin
            case ($urandom_range(0, 9))
                0:       c = CH_DOLLAR;
                1:       c = CH_CR;
                2:       c = CH_LF;
                3:       c = 8'h00;
                default: c = $urandom_range(0, 255);
            endcase
            send_char(c, $urandom());
        end
    endtask

    // Mostly sane date and time digits, sometimes any two or four digits
    task automatic send_random_sentence();
        text_t txt;
        int    hh, mi, ss, dd, mo, yy;
        hh = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 23);
        mi = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59);
        ss = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59);
        dd = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 31);
        mo = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
        yy = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 9999)
                                         : $urandom_range(1970, 2099);
        txt = zda_text(hh, mi, ss, dd, mo, yy);
        // corrupt a few bytes now and then; any byte value may land
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3))
                txt[$urandom_range(1, txt.size() - 1)] = $urandom_range(0, 255);
        case ($urandom_range(0, 15))
            0: txt.insert($urandom_range(1, 35), $urandom_range(8'h30, 8'h39));
            1: txt.delete($urandom_range(1, 35));
            2: txt[3] = "G";
            default: ;
        endcase
        send_text(txt);
        case ($urandom_range(0, 7))
            0, 1, 2: begin
                send_char(CH_CR, $urandom());
                send_char(CH_LF, $urandom());
            end
            3: send_char(CH_CR, $urandom());
            4: send_char(CH_LF, $urandom());
            5: begin
                send_char(CH_LF, $urandom());
                send_char(CH_CR, $urandom());
            end
            6: ;                              // no line end: the next '$' drops it
            default: begin
                send_char(CH_CR, $urandom());
                send_char($urandom_range(8'h20, 8'h7E), $urandom());
                send_char(CH_LF, $urandom());
            end
        endcase
    endtask

    task automatic test_random_traffic(int unsigned budget);
        int unsigned stop_at;
        stop_at = chars_sent + budget;
        while (chars_sent < stop_at) begin
            if ($urandom_range(0, 3) == 0)
                send_noise();
            else
                send_random_sentence();
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : run_tests
        foreach (line_buf[k])
            line_buf[k] = 8'h00;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_char_in   = 8'h00;
        s_now_ms    = '0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        test_text_before_dollar();
        test_plain_fix();
        test_field_extremes();
        test_broken_digits();
        test_odd_lengths();
        test_stalled_output();

        // random phases, each under its own offset; a quiet phase in the middle
        set_utc_offset($urandom_range(0, 100800) - 50400);
        test_random_traffic(90);
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        set_utc_offset($urandom_range(0, 100800) - 50400);
        test_random_traffic(90);
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        set_utc_offset(-50400);
        test_random_traffic(90);
        // last part runs with no idling on either side
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        set_utc_offset($urandom_range(0, 100800) - 50400);
        test_random_traffic(90);

        wait_idle();
        if (fix_mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
